// ===== rtl/srrs_pkg.sv =====
package srrs_pkg;

  localparam int SACK_BITS = 32;
  localparam int CNT_W     = $clog2(SACK_BITS + 1);

  localparam logic [15:0] MTU_PROBE_CEIL = 16'hFFFF - 16'd256;
  localparam logic [15:0] PROBE_EXTRA    = 16'd255;
  localparam logic [15:0] TICK_SAT       = 16'hFFFF;
  localparam logic [15:0] MTU_RESET      = 16'd508;
  localparam logic [15:0] LIMIT_RESET    = 16'd10;

  localparam logic [1:0] MODE_QUEUE = 2'd0;
  localparam logic [1:0] MODE_ACK   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  localparam logic [1:0] KIND_ASSIGN = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [1:0] REG_IDLE_LIMIT  = 2'd0;
  localparam logic [1:0] REG_PROBE_LIMIT = 2'd1;
  localparam logic [1:0] REG_INIT_MTU    = 2'd2;

  // window test result
  typedef struct packed {
    logic hit;    // index lies in [oldest, next)
    logic empty;  // nothing outstanding
  } win_t;

endpackage

// ===== rtl/srrs_window.sv =====
module srrs_window
  import srrs_pkg::*;
(
  input  logic [31:0] idx,
  input  logic [31:0] oldest,
  input  logic [31:0] next_seq,
  output win_t        win
);

  logic [31:0] offset;
  logic [31:0] count;

  // modular distance from the oldest outstanding index
  assign offset    = idx - oldest;
  assign count     = next_seq - oldest;
  assign win.hit   = offset < count;
  assign win.empty = (count == 32'd0);

endmodule

// ===== rtl/selective_repeat_resend_selector.sv =====
// Selective-repeat sender: assigns indices, picks the datagrams to resend from
// an ack and its SACK mask, and keeps probe and idle tick status. Queue and tick
// words give their result word on the cycle after start, and busy
// stays low, so one may be issued every cycle. An ack holds busy through a retire
// step, a scan of the acked index and the SACK_BITS mask bits through the shared window
// compare, and a flush step; each resend word is held back until the walk finds
// the next hit or reaches the flush step, so words come at most one per cycle,
// the last one flagged by out_last_of_run. An ack that resends nothing gives no
// word. Every result word is on the ports for exactly one cycle with out_strobe
// high and must be taken then: the receiver cannot stall the block.
module selective_repeat_resend_selector
  import srrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_ack_index,
  input  logic [31:0] in_ack_mask,
  input  logic [15:0] in_peer_mtu,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [31:0] out_seq_index,
  output logic        out_probe_request,
  output logic [15:0] out_probe_length,
  output logic        out_timed_out,
  output logic        out_link_failed,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] {ST_IDLE, ST_RETIRE, ST_SCAN, ST_FLUSH} state_t;

  state_t             state_r;
  logic [31:0]        oldest_r;
  logic [31:0]        next_seq_r;
  logic [15:0]        idle_ticks_r;
  logic [15:0]        probe_ticks_r;
  logic [15:0]        path_mtu_r;
  logic               failed_r;
  logic [15:0]        idle_limit_r;
  logic [15:0]        probe_limit_r;
  logic [31:0]        cand_r;
  logic [SACK_BITS:0] sel_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [15:0]        peer_mtu_r;
  logic [31:0]        pend_idx_r;
  logic               pend_v_r;

  logic        out_strobe_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_seq_r;
  logic        out_probe_r;
  logic [15:0] out_plen_r;
  logic        out_tmo_r;
  logic        out_failed_r;
  logic        out_last_r;

  win_t        win;
  logic        accept;
  logic [15:0] probe_inc;
  logic [15:0] idle_inc;
  logic        probe_now;
  logic        cand_hit;

  srrs_window u_window (
    .idx      (cand_r),
    .oldest   (oldest_r),
    .next_seq (next_seq_r),
    .win      (win)
  );

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  assign probe_inc = (probe_ticks_r == TICK_SAT) ? probe_ticks_r : probe_ticks_r + 16'd1;
  assign idle_inc  = (idle_ticks_r == TICK_SAT) ? idle_ticks_r : idle_ticks_r + 16'd1;
  assign probe_now = (probe_inc < probe_limit_r) && (path_mtu_r < MTU_PROBE_CEIL);
  assign cand_hit  = sel_r[0] & win.hit;

  always_ff @(posedge clk) begin
    out_strobe_r <= 1'b0;
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      oldest_r      <= '0;
      next_seq_r    <= '0;
      idle_ticks_r  <= '0;
      probe_ticks_r <= '0;
      path_mtu_r    <= MTU_RESET;
      failed_r      <= 1'b0;
      idle_limit_r  <= LIMIT_RESET;
      probe_limit_r <= LIMIT_RESET;
      pend_v_r      <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_index)
              REG_IDLE_LIMIT:  idle_limit_r  <= cfg_data;
              REG_PROBE_LIMIT: probe_limit_r <= cfg_data;
              REG_INIT_MTU:    path_mtu_r    <= cfg_data;
              default: ;
            endcase
          end
          if (accept) begin
            case (in_mode)
              MODE_QUEUE: begin
                next_seq_r   <= next_seq_r + 32'd1;
                failed_r     <= failed_r | (&next_seq_r);
                out_strobe_r <= 1'b1;
                out_kind_r   <= KIND_ASSIGN;
                out_seq_r    <= next_seq_r;
                out_probe_r  <= 1'b0;
                out_plen_r   <= '0;
                out_tmo_r    <= 1'b0;
                out_failed_r <= failed_r | (&next_seq_r);
                out_last_r   <= 1'b1;
              end
              MODE_ACK: begin
                cand_r     <= in_ack_index;
                sel_r      <= {SACK_BITS'(in_ack_mask), 1'b1};
                cnt_r      <= '0;
                peer_mtu_r <= in_peer_mtu;
                pend_v_r   <= 1'b0;
                state_r    <= ST_RETIRE;
              end
              MODE_TICK: begin
                probe_ticks_r <= probe_inc;
                idle_ticks_r  <= idle_inc;
                out_strobe_r  <= 1'b1;
                out_kind_r    <= KIND_TICK;
                out_seq_r     <= '0;
                out_probe_r   <= probe_now;
                out_plen_r    <= probe_now ? path_mtu_r + PROBE_EXTRA : 16'd0;
                out_tmo_r     <= idle_inc > idle_limit_r;
                out_failed_r  <= failed_r;
                out_last_r    <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_RETIRE: begin
          // window unit looks at the acked index itself here
          if (!win.empty && (cand_r > oldest_r)) begin
            oldest_r     <= win.hit ? cand_r : next_seq_r;
            idle_ticks_r <= '0;
          end
          if (path_mtu_r < peer_mtu_r) path_mtu_r <= peer_mtu_r;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          // hold each hit until the next hit or the flush so the final word can carry last_of_run
          if (cand_hit) begin
            if (pend_v_r) begin
              out_strobe_r <= 1'b1;
              out_kind_r   <= KIND_RESEND;
              out_seq_r    <= pend_idx_r;
              out_probe_r  <= 1'b0;
              out_plen_r   <= '0;
              out_tmo_r    <= 1'b0;
              out_failed_r <= failed_r;
              out_last_r   <= 1'b0;
            end
            pend_idx_r <= cand_r;
            pend_v_r   <= 1'b1;
          end
          cand_r <= cand_r + 32'd1;
          sel_r  <= sel_r >> 1;
          cnt_r  <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(SACK_BITS)) state_r <= ST_FLUSH;
        end
        ST_FLUSH: begin
          if (pend_v_r) begin
            out_strobe_r <= 1'b1;
            out_kind_r   <= KIND_RESEND;
            out_seq_r    <= pend_idx_r;
            out_probe_r  <= 1'b0;
            out_plen_r   <= '0;
            out_tmo_r    <= 1'b0;
            out_failed_r <= failed_r;
            out_last_r   <= 1'b1;
          end
          pend_v_r <= 1'b0;
          state_r  <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_kind          = out_kind_r;
  assign out_seq_index     = out_seq_r;
  assign out_probe_request = out_probe_r;
  assign out_probe_length  = out_plen_r;
  assign out_timed_out     = out_tmo_r;
  assign out_link_failed   = out_failed_r;
  assign out_last_of_run   = out_last_r;

endmodule

// ===== rtl/srrs_checker.sv =====
module srrs_checker
  import srrs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_mode,
  input logic        out_strobe,
  input logic [1:0]  out_kind,
  input logic        out_probe_request,
  input logic [15:0] out_probe_length,
  input logic        out_timed_out,
  input logic        out_last_of_run
);

  // a queued word is answered on the very next cycle
  a_queue_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_QUEUE |=>
      out_strobe && out_kind == KIND_ASSIGN && out_last_of_run)
    else $error("queue word not answered next cycle");

  a_tick_reply: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == MODE_TICK |=>
      out_strobe && out_kind == KIND_TICK && out_last_of_run)
    else $error("tick word not answered next cycle");

  a_resend_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_kind == KIND_RESEND |->
      !out_probe_request && out_probe_length == 16'd0 && !out_timed_out)
    else $error("resend word carries tick status");

  // probe length is mtu+255, never zero when requested
  a_probe_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_probe_request |-> out_probe_length != 16'd0)
    else $error("probe requested with zero length");

endmodule

bind selective_repeat_resend_selector srrs_checker u_srrs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_mode           (in_mode),
  .out_strobe        (out_strobe),
  .out_kind          (out_kind),
  .out_probe_request (out_probe_request),
  .out_probe_length  (out_probe_length),
  .out_timed_out     (out_timed_out),
  .out_last_of_run   (out_last_of_run)
);

// ===== verif/selective_repeat_resend_selector_tb.sv =====
module selective_repeat_resend_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srrs_pkg::*;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = SACK_BITS + 8;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ack;
    logic [31:0] mask;
    logic [15:0] pmtu;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic        probe;
    logic [15:0] plen;
    logic        tmo;
    logic        failed;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_mode = '0;
  logic [31:0] in_ack_index = '0;
  logic [31:0] in_ack_mask = '0;
  logic [15:0] in_peer_mtu = '0;
  logic        out_strobe;
  logic [1:0]  out_kind;
  logic [31:0] out_seq_index;
  logic        out_probe_request;
  logic [15:0] out_probe_length;
  logic        out_timed_out;
  logic        out_link_failed;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  cmd_t        pending_cmds[$];
  word_t       due_words[$];
  logic        took_item = 1'b0;
  int          gap_pct = 0;
  int          errors = 0;
  int          cycles = 0;
  logic [31:0] issued = '0;

  // sender state as the block should hold it
  logic [15:0] lim_idle = LIMIT_RESET;
  logic [15:0] lim_probe = LIMIT_RESET;
  logic [15:0] mtu = MTU_RESET;
  logic [31:0] win_oldest = '0;
  logic [31:0] win_next = '0;
  logic [15:0] idle_cnt = '0;
  logic [15:0] probe_cnt = '0;
  logic        link_down = 1'b0;

  selective_repeat_resend_selector DUT (.*);

  always #5 clk = ~clk;

  function automatic bit in_window(logic [31:0] idx);
    logic [31:0] offs, span;
    offs = idx - win_oldest;
    span = win_next - win_oldest;
    return offs < span;
  endfunction

  function automatic void load_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_IDLE_LIMIT:  lim_idle = val;
      REG_PROBE_LIMIT: lim_probe = val;
      REG_INIT_MTU:    mtu = val;
      default: ;
    endcase
  endfunction

  function automatic void sender_step(logic [1:0] mode, logic [31:0] ack, logic [31:0] mask,
                                      logic [15:0] pmtu);
    word_t       run[$];
    word_t       r;
    logic [31:0] span, offs, idx;
    r = '0;
    case (mode)
      MODE_QUEUE: begin
        r.kind = KIND_ASSIGN;
        r.seq = win_next;
        win_next = win_next + 32'd1;
        if (win_next == 32'd0) link_down = 1'b1;
        r.failed = link_down;
        run = {run, r};
      end
      MODE_ACK: begin
        span = win_next - win_oldest;
        offs = ack - win_oldest;
        if (span != 32'd0 && ack > win_oldest) begin
          win_oldest = (offs < span) ? ack : win_next;
          idle_cnt = '0;
        end
        r.kind = KIND_RESEND;
        r.failed = link_down;
        if (in_window(ack)) begin
          r.seq = ack;
          run = {run, r};
        end
        for (int k = 0; k < SACK_BITS; k++) begin
          idx = ack + k + 1;
          if (mask[k] && in_window(idx)) begin
            r.seq = idx;
            run = {run, r};
          end
        end
        if (mtu < pmtu) mtu = pmtu;
      end
      MODE_TICK: begin
        if (probe_cnt != TICK_SAT) probe_cnt = probe_cnt + 16'd1;
        if (idle_cnt != TICK_SAT) idle_cnt = idle_cnt + 16'd1;
        r.kind = KIND_TICK;
        r.probe = (probe_cnt < lim_probe) && (mtu < MTU_PROBE_CEIL);
        r.plen = r.probe ? mtu + PROBE_EXTRA : 16'd0;
        r.tmo = idle_cnt > lim_idle;
        r.failed = link_down;
        run = {run, r};
      end
      default: ;
    endcase
    if (run.size() != 0) begin
      r = run.pop_back();
      r.last = 1'b1;
      run = {run, r};
    end
    due_words = {due_words, run};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void add_cmd(logic [1:0] mode, logic [31:0] ack, logic [31:0] mask,
                                  logic [15:0] pmtu);
    cmd_t c;
    c.mode = mode;
    c.ack = ack;
    c.mask = mask;
    c.pmtu = pmtu;
    pending_cmds = {pending_cmds, c};
    if (mode == MODE_QUEUE) issued = issued + 32'd1;
  endfunction

  function automatic void add_random_cmd();
    int          pick;
    logic [1:0]  mode;
    logic [31:0] ack, mask;
    logic [15:0] pmtu;
    pick = $urandom_range(99);
    ack = $urandom;
    mask = $urandom;
    case ($urandom_range(9))
      0: pmtu = MTU_PROBE_CEIL - 16'd1;
      1: pmtu = MTU_PROBE_CEIL;
      2: pmtu = 16'($urandom);
      default: pmtu = 16'($urandom_range(1500));
    endcase
    if (pick < 42) begin
      mode = MODE_QUEUE;
    end else if (pick < 66) begin
      // ack based near the head so retires and resends actually land
      mode = MODE_ACK;
      ack = issued - $urandom_range(40);
      case ($urandom_range(3))
        0: mask = 32'h1 << $urandom_range(31);
        1: mask = $urandom & $urandom;
        2: mask = '0;
        default: ;
      endcase
    end else if (pick < 71) begin
      mode = MODE_ACK;
    end else if (pick < 96) begin
      mode = MODE_TICK;
    end else begin
      mode = MODE_UNUSED;
    end
    add_cmd(mode, ack, mask, pmtu);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] idle_lim, logic [15:0] probe_lim, logic [15:0] mtu0);
    write_reg(REG_IDLE_LIMIT, idle_lim);
    write_reg(REG_PROBE_LIMIT, probe_lim);
    write_reg(REG_INIT_MTU, mtu0);
  endtask

  // all words in, all results back, then room for an ack that resends nothing
  task automatic settle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || busy || due_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(posedge clk) took_item <= start && !busy;

  always @(negedge clk) begin : driver
    cmd_t c;
    if (rst_n && (!start || took_item)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        c = pending_cmds.pop_front();
        start <= 1'b1;
        in_mode <= c.mode;
        in_ack_index <= c.ack;
        in_ack_mask <= c.mask;
        in_peer_mtu <= c.pmtu;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    word_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got kind %0d seq %0h",
                   $time, out_kind, out_seq_index);
          errors++;
        end else begin
          want = due_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("seq_index", want.seq, out_seq_index);
          check_field("probe_request", 32'(want.probe), 32'(out_probe_request));
          check_field("probe_length", 32'(want.plen), 32'(out_probe_length));
          check_field("timed_out", 32'(want.tmo), 32'(out_timed_out));
          check_field("link_failed", 32'(want.failed), 32'(out_link_failed));
          check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
        end
      end
      if (cfg_valid && cfg_ready) load_reg(cfg_index, cfg_data);
      if (start && !busy) sender_step(in_mode, in_ack_index, in_ack_mask, in_peer_mtu);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("selective_repeat_resend_selector_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    add_cmd(MODE_TICK, '0, '0, '0);
    add_cmd(MODE_UNUSED, '1, '1, '1);
    repeat (SACK_BITS + 2) add_cmd(MODE_QUEUE, '0, '0, '0);
    add_cmd(MODE_ACK, 32'd0, '1, 16'd0);                 // full mask: longest run
    add_cmd(MODE_ACK, 32'd5, 32'h8000_0001, 16'd1500);   // retire, top bit past head
    add_cmd(MODE_ACK, 32'd2, 32'hFFFF_0000, 16'd100);    // base already retired
    add_cmd(MODE_ACK, '1, 32'h3, '0);                    // past the head: window empties
    repeat (LIMIT_RESET + 2) add_cmd(MODE_TICK, '0, '0, '0);
    add_cmd(MODE_QUEUE, '0, '0, '0);
    add_cmd(MODE_QUEUE, '0, '0, '0);
    add_cmd(MODE_ACK, issued - 32'd1, '0, '1);
    add_cmd(MODE_TICK, '0, '0, '0);
    settle();

    set_regs(16'd0, 16'hFFFF, 16'd0);
    @(posedge clk);
    gap_pct = 0;
    repeat (100) add_random_cmd();
    settle();

    set_regs(16'hFFFF, 16'd0, 16'hFFFF);
    @(posedge clk);
    gap_pct = 86;
    repeat (100) add_random_cmd();
    settle();

    set_regs(16'd3, 16'd20, 16'd1200);
    @(posedge clk);
    gap_pct = 15;
    repeat (110) add_random_cmd();
    settle();

    // tick saturation needs 2^16 tick words and the index wrap 2^32 queue words,
    // both out of reach here, so link_failed is only seen low
    set_regs(16'hFFFF, 16'hFFFF, MTU_PROBE_CEIL - 16'd1);
    @(posedge clk);
    gap_pct = 0;
    repeat (8) add_cmd(MODE_TICK, '0, '0, '0);
    add_cmd(MODE_QUEUE, '0, '0, '0);
    add_cmd(MODE_ACK, issued, '0, '0);
    add_cmd(MODE_TICK, '0, '0, '0);
    settle();

    if (errors == 0) begin
      $display("selective_repeat_resend_selector_tb: clean");
    end else begin
      $display("selective_repeat_resend_selector_tb: errors");
    end
    $finish;
  end

endmodule
